/* src/pde_pkg.sv */
package pde_pkg;

  typedef logic [7:0] byte_t;

  localparam int RUN_MAX = 7;
  localparam int TOK_MAX = 3;
  localparam int PADDR_W = 3;

  // Register index taken from paddr[2]
  localparam logic REG_DECODE_ENABLE = 1'b0;

  localparam byte_t CH_NUL  = 8'h00;
  localparam byte_t CH_HASH = 8'h23;
  localparam byte_t CH_PCT  = 8'h25;
  localparam byte_t CH_AMP  = 8'h26;
  localparam byte_t CH_ZERO = 8'h30;
  localparam byte_t CH_SEMI = 8'h3B;
  localparam byte_t CH_LT   = 8'h3C;
  localparam byte_t CH_GT   = 8'h3E;
  localparam byte_t CH_A    = 8'h61;
  localparam byte_t CH_G    = 8'h67;
  localparam byte_t CH_L    = 8'h6C;
  localparam byte_t CH_M    = 8'h6D;
  localparam byte_t CH_P    = 8'h70;
  localparam byte_t CH_T    = 8'h74;

  typedef struct packed {
    logic [RUN_MAX-1:0][7:0] bytes;
    logic [2:0]              cnt;
    logic                    last;
  } run_t;

  // Bit 4 set: not a hex digit; bits 3:0 the digit value otherwise
  function automatic logic [4:0] hex_val(byte_t b);
    logic [4:0] r;
    r = 5'h10;
    if (b >= 8'h30 && b <= 8'h39) r = {1'b0, 4'(b - 8'h30)};
    else if (b >= 8'h41 && b <= 8'h46) r = {1'b0, 4'(b - 8'h37)};
    else if (b >= 8'h61 && b <= 8'h66) r = {1'b0, 4'(b - 8'h57)};
    return r;
  endfunction

  function automatic logic [2:0] esc_len(byte_t b);
    logic [2:0] r;
    case (b)
      CH_LT:   r = 3'd4;
      CH_GT:   r = 3'd4;
      CH_AMP:  r = 3'd5;
      CH_NUL:  r = 3'd5;
      default: r = 3'd1;
    endcase
    return r;
  endfunction

  // Character k of the escaped form of b
  function automatic byte_t esc_char(byte_t b, logic [2:0] k);
    byte_t r;
    r = CH_SEMI;
    case (b)
      CH_LT: begin
        case (k)
          3'd0:    r = CH_AMP;
          3'd1:    r = CH_L;
          3'd2:    r = CH_T;
          default: r = CH_SEMI;
        endcase
      end
      CH_GT: begin
        case (k)
          3'd0:    r = CH_AMP;
          3'd1:    r = CH_G;
          3'd2:    r = CH_T;
          default: r = CH_SEMI;
        endcase
      end
      CH_AMP: begin
        case (k)
          3'd0:    r = CH_AMP;
          3'd1:    r = CH_A;
          3'd2:    r = CH_M;
          3'd3:    r = CH_P;
          default: r = CH_SEMI;
        endcase
      end
      CH_NUL: begin
        case (k)
          3'd0:    r = CH_AMP;
          3'd1:    r = CH_HASH;
          3'd2:    r = CH_ZERO;
          3'd3:    r = CH_ZERO;
          default: r = CH_SEMI;
        endcase
      end
      default: r = b;
    endcase
    return r;
  endfunction

endpackage

/* src/pde_if.sv */
interface pde_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface pde_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       message_end;

  modport source (output valid, output out_byte, output run_last, output message_end,
                  input ready);
  modport sink (input valid, input out_byte, input run_last, input message_end,
                output ready);
endinterface

/* src/pde_apb_regs.sv */
module pde_apb_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pde_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output logic                       decode_enable
);
  import pde_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_DECODE_ENABLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      decode_enable <= 1'b1;
    end else if (wr_en) begin
      decode_enable <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == REG_DECODE_ENABLE) ? {31'd0, decode_enable} : 32'd0;
endmodule

/* src/pde_decoder.sv */
module pde_decoder (
  input  logic          clk,
  input  logic          rst,
  input  logic          decode_enable,
  input  logic          take,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  output pde_pkg::run_t run
);
  import pde_pkg::*;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_PCT   = 2'd1;
  localparam logic [1:0] PH_DIGIT = 2'd2;

  logic [1:0] decode_phase, decode_phase_next;
  byte_t      pending_digit, pending_digit_next;

  logic [1:0]              ph;
  logic [4:0]              hb;
  logic [4:0]              hp;
  logic                    is_hex;
  logic [TOK_MAX-1:0][7:0] tok;
  logic [1:0]              ntok;
  logic [2:0]              l0, l1, l2;
  logic [3:0]              o2, total;

  always_comb begin
    ph     = (decode_phase == PH_PCT || decode_phase == PH_DIGIT) ? decode_phase : PH_IDLE;
    hb     = hex_val(in_byte);
    hp     = hex_val(pending_digit);
    is_hex = !hb[4];
    tok    = '0;
    ntok   = 2'd0;
    decode_phase_next  = ph;
    pending_digit_next = pending_digit;

    // Release held characters on a broken escape or with decoding off
    if (!decode_enable || (ph != PH_IDLE && !is_hex)) begin
      if (ph != PH_IDLE) begin
        tok[ntok] = CH_PCT;
        ntok      = ntok + 2'd1;
      end
      if (ph == PH_DIGIT) begin
        tok[ntok] = pending_digit;
        ntok      = ntok + 2'd1;
      end
      decode_phase_next  = PH_IDLE;
      pending_digit_next = '0;
    end

    if (decode_enable && ph == PH_PCT && is_hex) begin
      decode_phase_next  = PH_DIGIT;
      pending_digit_next = in_byte;
    end else if (decode_enable && ph == PH_DIGIT && is_hex) begin
      tok[ntok]          = {hp[3:0], hb[3:0]};
      ntok               = ntok + 2'd1;
      decode_phase_next  = PH_IDLE;
      pending_digit_next = '0;
    end else if (decode_enable && in_byte == CH_PCT) begin
      decode_phase_next  = PH_PCT;
      pending_digit_next = '0;
    end else begin
      tok[ntok]          = in_byte;
      ntok               = ntok + 2'd1;
      decode_phase_next  = PH_IDLE;
      pending_digit_next = '0;
    end

    // Final byte: flush whatever is still held
    if (in_last) begin
      if (decode_phase_next != PH_IDLE) begin
        tok[ntok] = CH_PCT;
        ntok      = ntok + 2'd1;
      end
      if (decode_phase_next == PH_DIGIT) begin
        tok[ntok] = pending_digit_next;
        ntok      = ntok + 2'd1;
      end
      decode_phase_next  = PH_IDLE;
      pending_digit_next = '0;
    end
  end

  // Lay the escaped tokens out one after another
  always_comb begin
    l0    = (ntok > 2'd0) ? esc_len(tok[0]) : 3'd0;
    l1    = (ntok > 2'd1) ? esc_len(tok[1]) : 3'd0;
    l2    = (ntok > 2'd2) ? esc_len(tok[2]) : 3'd0;
    o2    = {1'b0, l0} + {1'b0, l1};
    total = o2 + {1'b0, l2};
    for (int j = 0; j < RUN_MAX; j++) begin
      if (4'(j) < {1'b0, l0}) begin
        run.bytes[j] = esc_char(tok[0], 3'(j));
      end else if (4'(j) < o2) begin
        run.bytes[j] = esc_char(tok[1], 3'(4'(j) - {1'b0, l0}));
      end else begin
        run.bytes[j] = esc_char(tok[2], 3'(4'(j) - o2));
      end
    end
    run.cnt  = total[2:0];
    run.last = in_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      decode_phase  <= PH_IDLE;
      pending_digit <= '0;
    end else if (take) begin
      decode_phase  <= decode_phase_next;
      pending_digit <= pending_digit_next;
    end
  end
endmodule

/* src/pde_emitter.sv */
module pde_emitter (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  pde_pkg::run_t run,
  output logic          free,
  pde_out_if.source     esc
);
  import pde_pkg::*;

  logic [RUN_MAX-1:0][7:0] run_buf;
  logic [2:0]              cnt;
  logic                    run_end;
  logic                    c_ready;
  logic                    emit;

  assign c_ready = !esc.valid || esc.ready;
  assign emit    = (cnt != 3'd0) && c_ready;
  assign free    = (cnt == 3'd0) || (emit && cnt == 3'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 3'd0;
    end else if (load) begin
      cnt <= run.cnt;
    end else if (emit) begin
      cnt <= cnt - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      run_buf <= run.bytes;
      run_end <= run.last;
    end else if (emit) begin
      run_buf <= run_buf >> 8;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      esc.valid <= 1'b0;
    end else if (c_ready) begin
      esc.valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      esc.out_byte    <= run_buf[0];
      esc.run_last    <= (cnt == 3'd1);
      esc.message_end <= (cnt == 3'd1) && run_end;
    end
  end
endmodule

/* src/percent_decode_xml_escape.sv */
// Percent decoder and XML escaper for a byte stream. Each input item is one text byte plus a
// flag on the final byte of a message; with decode_enable set (register 0, reset 1) a '%'
// followed by two hex digits becomes the encoded byte, and every byte that comes out of the
// decoder is XML-escaped ('<' '>' '&' NUL become &lt; &gt; &amp; &#00;). Each input item gives
// 0 to 7 output items; run_last marks the last output item of an input item and message_end
// the last one of a message. Dataflow: an input item enters an input register, is decoded
// and expanded combinationally into a run buffer, which drains one byte a cycle into the
// output register while the output is not stalled. The run buffer and its single-byte
// output register set the rate: bytes that need no escape and items held by the decoder flow
// at one item per cycle while the output is not stalled, and an item that yields 4 or 5 bytes
// for an entity holds the output until they are sent. Configuration is to be written over the
// APB port only while the block is idle; the block itself does not enforce this.
module percent_decode_xml_escape (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pde_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  pde_in_if.sink                      raw,
  pde_out_if.source                   esc
);
  import pde_pkg::*;

  logic       decode_enable;
  logic       a_valid;
  byte_t      a_byte;
  logic       a_last;
  logic       a_adv;
  logic       run_free;
  run_t       run;

  pde_apb_regs u_regs (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .decode_enable (decode_enable)
  );

  // Advance the held item when its run fits: an item that yields nothing only updates state
  assign a_adv     = a_valid && ((run.cnt == 3'd0) || run_free);
  assign raw.ready = !a_valid || a_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (raw.ready) begin
      a_valid <= raw.valid;
    end
  end

  // Hold the input byte until the decoder takes it
  always_ff @(posedge clk) begin
    if (raw.valid && raw.ready) begin
      a_byte <= raw.in_byte;
      a_last <= raw.in_last;
    end
  end

  pde_decoder u_decoder (
    .clk           (clk),
    .rst           (rst),
    .decode_enable (decode_enable),
    .take          (a_adv),
    .in_byte       (a_byte),
    .in_last       (a_last),
    .run           (run)
  );

  pde_emitter u_emitter (
    .clk  (clk),
    .rst  (rst),
    .load (a_adv && (run.cnt != 3'd0)),
    .run  (run),
    .free (run_free),
    .esc  (esc)
  );
endmodule

/* src/pde_checker.sv */
module pde_checker (
  input logic       clk,
  input logic       rst,
  input logic       esc_valid,
  input logic       esc_ready,
  input logic [7:0] out_byte,
  input logic       run_last,
  input logic       message_end
);
  import pde_pkg::*;

  // A stalled output item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    esc_valid && !esc_ready |=> esc_valid && $stable(out_byte) && $stable(run_last)
      && $stable(message_end))
    else $error("output item changed while stalled");

  // The end of a message is always the end of a run
  a_end_in_run: assert property (@(posedge clk) disable iff (rst)
    esc_valid && message_end |-> run_last)
    else $error("message_end without run_last");

  // NUL is always escaped, so it never leaves the block
  a_no_nul: assert property (@(posedge clk) disable iff (rst)
    esc_valid |-> out_byte != CH_NUL)
    else $error("raw NUL on output");

  // Reset drops any pending output
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !esc_valid)
    else $error("output valid after reset");
endmodule

bind percent_decode_xml_escape pde_checker u_pde_checker (
  .clk         (clk),
  .rst         (rst),
  .esc_valid   (esc.valid),
  .esc_ready   (esc.ready),
  .out_byte    (esc.out_byte),
  .run_last    (esc.run_last),
  .message_end (esc.message_end)
);

/* tb/tb_percent_decode_xml_escape.sv */
`timescale 1ns / 1ps

// Regression for percent_decode_xml_escape.
//
// Text bytes go into the raw channel. A percent decoder in the testbench tracks the decoder
// phase, the held hex digit and the decode_enable register. For every accepted input item it
// pushes the escaped bytes that item should produce onto expected_text. A separate process
// pops one entry for each byte accepted on the esc channel and compares out_byte, run_last and
// message_end against it.
//
// Test order:
//   register access   reset value, readback, low-bit masking, write to an unused address
//   entity escapes    NUL, '<', '>', '&', byte extremes
//   percent decode    escapes in both letter cases, decoded bytes that need escaping
//   broken escapes    bad byte in either phase, '%' restarting an escape, flush on the final
//                     byte from either phase
//   decode disabled   held '%' and digit released when decoding is turned off, widest run
//   random messages   well-formed escapes, plain and entity bytes, broken escapes; the
//                     register changes between phases and idling is switched per phase
//   backpressure      long stall on the output while the input keeps offering items, plus
//                     a pause of the sender until every result is back
module tb_percent_decode_xml_escape;
  import pde_pkg::*;

  localparam logic [PADDR_W-1:0] ADDR_DECODE_ENABLE = {REG_DECODE_ENABLE, 2'b00};
  // Index 1 is past the last register
  localparam logic [PADDR_W-1:0] ADDR_UNUSED        = 3'd4;
  // Input register, run buffer and output register, plus margin
  localparam int                 SETTLE_CYCLES      = 8;
  localparam int                 DRAIN_LIMIT        = 20000;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } dec_phase_t;

  typedef struct packed {
    byte_t data;
    logic  run_last;
    logic  msg_end;
  } esc_item_t;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  pde_in_if  raw_if ();
  pde_out_if esc_if ();

  percent_decode_xml_escape dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .raw     (raw_if),
    .esc     (esc_if)
  );

  // Decoder state as the block should hold it
  logic       dec_enable;
  dec_phase_t dec_phase;
  byte_t      dec_digit;

  esc_item_t  expected_text[$];
  byte_t      run_bytes[$];

  int         n_bad;
  int         items_sent;
  bit         src_idle_on;
  bit         sink_idle_on;
  int         hold_ready_cycles;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------------------

  // Value of a hex digit in either case, -1 for any other byte
  function automatic int hex_nibble(byte_t c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    return -1;
  endfunction

  // Append the escaped form of one decoded byte to the current run
  function automatic void emit_text(byte_t c);
    string ent;
    case (c)
      CH_LT:   ent = "&lt;";
      CH_GT:   ent = "&gt;";
      CH_AMP:  ent = "&amp;";
      CH_NUL:  ent = "&#00;";
      default: ent = "";
    endcase
    if (ent.len() == 0) begin
      run_bytes.push_back(c);
    end else begin
      for (int i = 0; i < ent.len(); i++) run_bytes.push_back(byte_t'(ent[i]));
    end
  endfunction

  // Give back whatever the decoder holds as plain text and go idle
  function automatic void release_held();
    if (dec_phase == PH_PCT) begin
      emit_text(CH_PCT);
    end else if (dec_phase == PH_DIGIT) begin
      emit_text(CH_PCT);
      emit_text(dec_digit);
    end
    dec_phase = PH_IDLE;
    dec_digit = '0;
  endfunction

  function automatic void take_idle(byte_t c);
    if (c == CH_PCT) dec_phase = PH_PCT;
    else emit_text(c);
  endfunction

  // Advance the decoder by one input item and queue the bytes it releases
  function automatic void predict_escape(byte_t c, logic last);
    esc_item_t it;
    int        lo;
    run_bytes.delete();
    lo = hex_nibble(c);
    if (!dec_enable) begin
      release_held();
      emit_text(c);
    end else begin
      case (dec_phase)
        PH_IDLE: take_idle(c);
        PH_PCT: begin
          if (lo >= 0) begin
            dec_digit = c;
            dec_phase = PH_DIGIT;
          end else begin
            release_held();
            take_idle(c);
          end
        end
        default: begin
          if (lo >= 0) begin
            emit_text(byte_t'((hex_nibble(dec_digit) << 4) | lo));
            dec_phase = PH_IDLE;
            dec_digit = '0;
          end else begin
            release_held();
            take_idle(c);
          end
        end
      endcase
    end
    if (last) release_held();
    foreach (run_bytes[k]) begin
      it.data     = run_bytes[k];
      it.run_last = (k == run_bytes.size() - 1);
      it.msg_end  = it.run_last && last;
      expected_text.push_back(it);
    end
  endfunction

  // ---------------------------------------------------------------------------------------
  // Shared drivers
  // ---------------------------------------------------------------------------------------

  task automatic report(string msg);
    n_bad++;
    if (n_bad <= 10) $display("%s", msg);
  endtask

  // Offer one item, after a random gap when src_idle_on is set, and hold it until accepted. valid stays high on
  // return; the next call or settle decides whether it drops.
  task automatic feed_byte(byte_t c, logic last);
    int gap;
    gap = src_idle_on ? $urandom_range(0, 9) : 0;
    @(negedge clk);
    if (gap > 0) begin
      raw_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    raw_if.in_byte <= c;
    raw_if.in_last <= last;
    raw_if.valid   <= 1'b1;
    do @(posedge clk); while (!raw_if.ready);
    predict_escape(c, last);
    items_sent++;
  endtask

  // Drop valid, wait for every expected byte, then let the pipeline go quiet
  task automatic settle();
    int guard;
    guard = 0;
    @(negedge clk);
    raw_if.valid <= 1'b0;
    while (expected_text.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    if (expected_text.size() != 0) begin
      report($sformatf("%0d expected output bytes never arrived", expected_text.size()));
      expected_text.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(logic [PADDR_W-1:0] addr, logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_DECODE_ENABLE) dec_enable = data[0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Read decode_enable back and compare with the value the predictor holds
  task automatic check_enable_reg();
    logic [31:0] rdata;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_DECODE_ENABLE;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rdata !== {31'b0, dec_enable})
      report($sformatf("decode_enable readback: expected %08h, got %08h",
                       {31'b0, dec_enable}, rdata));
  endtask

  function automatic byte_t hex_char(logic [3:0] v, logic upper);
    if (v < 4'd10) return byte_t'("0") + byte_t'(v);
    return (upper ? byte_t'("A") : byte_t'("a")) + byte_t'(v - 4'd10);
  endfunction

  // Build one message from escapes, plain bytes, entity bytes and broken escapes
  task automatic send_random_message();
    byte_t text[$];
    int    tokens;
    int    pick;
    tokens = $urandom_range(1, 8);
    repeat (tokens) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        text.push_back(CH_PCT);
        text.push_back(hex_char(4'($urandom), 1'($urandom)));
        text.push_back(hex_char(4'($urandom), 1'($urandom)));
      end else if (pick == 4) begin
        // Escape that decodes to a byte which itself needs an entity
        text.push_back(CH_PCT);
        case ($urandom_range(0, 3))
          0: begin text.push_back("3"); text.push_back("c"); end
          1: begin text.push_back("3"); text.push_back("E"); end
          2: begin text.push_back("2"); text.push_back("6"); end
          default: begin text.push_back("0"); text.push_back("0"); end
        endcase
      end else if (pick == 5) begin
        case ($urandom_range(0, 3))
          0: text.push_back(CH_LT);
          1: text.push_back(CH_GT);
          2: text.push_back(CH_AMP);
          default: text.push_back(CH_NUL);
        endcase
      end else if (pick == 6) begin
        // Broken escape: '%', maybe one digit, then a byte that is rarely hex
        text.push_back(CH_PCT);
        if ($urandom_range(0, 1)) text.push_back(hex_char(4'($urandom), 1'($urandom)));
        case ($urandom_range(0, 3))
          0: text.push_back(CH_PCT);
          1: text.push_back(CH_AMP);
          2: text.push_back("g");
          default: text.push_back(byte_t'($urandom_range(0, 255)));
        endcase
      end else begin
        text.push_back(byte_t'($urandom_range(0, 255)));
      end
    end
    foreach (text[i]) feed_byte(text[i], i == text.size() - 1);
  endtask

  // ---------------------------------------------------------------------------------------
  // Output side: random stall per byte while sink_idle_on is set, and a long hold-off when a test asks for one
  // ---------------------------------------------------------------------------------------
  initial begin : esc_receiver
    int stall;
    esc_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      stall = sink_idle_on ? $urandom_range(0, 9) : 0;
      if (hold_ready_cycles > 0) begin
        stall = hold_ready_cycles;
        hold_ready_cycles = 0;
      end
      if (stall > 0) begin
        esc_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      esc_if.ready <= 1'b1;
      do @(posedge clk); while (!esc_if.valid);
    end
  end

  // Compare every accepted output byte with the oldest expectation
  always @(posedge clk) begin
    esc_item_t want;
    if (!rst && esc_if.valid && esc_if.ready) begin
      if (expected_text.size() == 0) begin
        report($sformatf("unexpected output byte %02h run_last %0b message_end %0b",
                         esc_if.out_byte, esc_if.run_last, esc_if.message_end));
      end else begin
        want = expected_text.pop_front();
        if (esc_if.out_byte !== want.data || esc_if.run_last !== want.run_last ||
            esc_if.message_end !== want.msg_end)
          report($sformatf({"output mismatch: expected byte %02h run_last %0b ",
                            "message_end %0b, got byte %02h run_last %0b message_end %0b"},
                           want.data, want.run_last, want.msg_end, esc_if.out_byte,
                           esc_if.run_last, esc_if.message_end));
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------------

  task automatic test_register_access();
    check_enable_reg();                          // reset value
    apb_write(ADDR_DECODE_ENABLE, 32'h0000_0000);
    check_enable_reg();
    apb_write(ADDR_UNUSED, 32'hFFFF_FFFF);       // must not reach decode_enable
    check_enable_reg();
    apb_write(ADDR_DECODE_ENABLE, 32'hFFFF_FFFE); // only bit 0 counts
    check_enable_reg();
    apb_write(ADDR_DECODE_ENABLE, 32'h0000_0003);
    check_enable_reg();
  endtask

  task automatic test_entity_escapes();
    feed_byte(CH_NUL, 1'b0);
    feed_byte(CH_LT, 1'b0);
    feed_byte(CH_GT, 1'b0);
    feed_byte(CH_AMP, 1'b0);
    feed_byte(8'hFF, 1'b1);
    settle();
  endtask

  task automatic test_percent_decode();
    // %3C decodes to '<' and comes out as an entity
    feed_byte(CH_PCT, 1'b0);
    feed_byte("3", 1'b0);
    feed_byte("C", 1'b0);
    // %00 decodes to NUL
    feed_byte(CH_PCT, 1'b0);
    feed_byte("0", 1'b0);
    feed_byte("0", 1'b0);
    // mixed case, byte value AF, ends the message
    feed_byte(CH_PCT, 1'b0);
    feed_byte("a", 1'b0);
    feed_byte("F", 1'b1);
    settle();
  endtask

  task automatic test_broken_escapes();
    // bad byte right after '%'
    feed_byte(CH_PCT, 1'b0);
    feed_byte("G", 1'b0);
    // '%' after one digit releases both and starts a new escape: %26 gives '&'
    feed_byte(CH_PCT, 1'b0);
    feed_byte("4", 1'b0);
    feed_byte(CH_PCT, 1'b0);
    feed_byte("2", 1'b0);
    feed_byte("6", 1'b0);
    // final byte is a lone '%'
    feed_byte(CH_PCT, 1'b1);
    // final byte leaves '%' and a digit held
    feed_byte(CH_PCT, 1'b0);
    feed_byte("b", 1'b1);
    settle();
  endtask

  task automatic test_decode_disabled();
    // hold '%' and a digit, then turn decoding off while the block is idle
    feed_byte(CH_PCT, 1'b0);
    feed_byte("7", 1'b0);
    settle();
    apb_write(ADDR_DECODE_ENABLE, 32'h0000_0000);
    // held text comes out ahead of "&amp;": seven bytes from one item
    feed_byte(CH_AMP, 1'b0);
    feed_byte(CH_PCT, 1'b1);
    settle();
    apb_write(ADDR_DECODE_ENABLE, 32'h0000_0001);
  endtask

  task automatic test_random_messages();
    logic [31:0] wdata;
    int          target;
    for (int p = 0; p < 6; p++) begin
      wdata    = $urandom();
      wdata[0] = (p % 3 != 1);
      apb_write(ADDR_DECODE_ENABLE, wdata);
      // walk through every combination of input and output idling
      src_idle_on  = p[0];
      sink_idle_on = p[1] | p[2];
      target = items_sent + 58;
      while (items_sent < target) send_random_message();
      settle();
    end
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  task automatic test_output_backpressure();
    int target;
    apb_write(ADDR_DECODE_ENABLE, 32'h0000_0001);
    // stall the output for a long stretch while input items keep coming back to back
    src_idle_on       = 1'b0;
    hold_ready_cycles = 300;
    target = items_sent + 40;
    while (items_sent < target) send_random_message();
    // pause the sender mid-stream until every result is back
    settle();
    hold_ready_cycles = 200;
    for (int i = 0; i < 24; i++) feed_byte(i[0] ? CH_NUL : CH_AMP, i == 23);
    settle();
    src_idle_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------------------
  initial begin
    rst               = 1'b1;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    raw_if.valid      = 1'b0;
    raw_if.in_byte    = '0;
    raw_if.in_last    = 1'b0;
    dec_enable        = 1'b1;
    dec_phase         = PH_IDLE;
    dec_digit         = '0;
    n_bad             = 0;
    items_sent        = 0;
    src_idle_on       = 1'b1;
    sink_idle_on      = 1'b1;
    hold_ready_cycles = 0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_register_access();
    test_entity_escapes();
    test_percent_decode();
    test_broken_escapes();
    test_decode_disabled();
    test_random_messages();
    test_output_backpressure();
    settle();

    if (n_bad == 0) begin
      $display("percent_decode_xml_escape regression: pass");
    end else begin
      $display("percent_decode_xml_escape regression: fail");
    end
    $finish;
  end

  // Hang guard, many times the slowest legal run
  initial begin
    #5_000_000;
    $display("percent_decode_xml_escape regression: fail");
    $finish;
  end

endmodule

/* filelist.f */
src/pde_pkg.sv
src/pde_if.sv
src/pde_apb_regs.sv
src/pde_decoder.sv
src/pde_emitter.sv
src/percent_decode_xml_escape.sv
src/pde_checker.sv
tb/tb_percent_decode_xml_escape.sv
